>>> rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Types, codes and helper functions shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int QBITS = 33;
   localparam logic [15:0] TOL_RESET = 16'd7;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;
   localparam logic [1:0] KIND_MUL = 2'd2;
   localparam logic [1:0] KIND_DIV = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DIVZ = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   typedef enum logic [2:0] {
      PATH_ADD,
      PATH_SUB,
      PATH_MUL,
      PATH_DIVR,
      PATH_DIVZ,
      PATH_DIVC
   } path_type;

   typedef struct packed {
      logic        neg;
      logic [31:0] mag;
   } sm32_type;

   typedef struct packed {
      logic        neg;
      logic [63:0] mag;
   } sm_type;

   typedef struct packed {
      logic        valid;
      path_type    path;
      logic [31:0] a_real;
      logic [31:0] a_imag;
      sm32_type    ar;
      sm32_type    ai;
      sm32_type    br;
      sm32_type    bi;
   } dec_type;

   typedef struct packed {
      logic        valid;
      path_type    path;
      logic [31:0] a_real;
      logic [31:0] a_imag;
      sm32_type    ar;
      sm32_type    ai;
      sm32_type    br;
      sm32_type    bi;
      sm_type      p_arbr;
      sm_type      p_aibi;
      sm_type      p_aibr;
      sm_type      p_arbi;
      sm_type      p_brbr;
      sm_type      p_bibi;
   } prod_type;

   typedef struct packed {
      logic        valid;
      path_type    path;
      logic [31:0] a_real;
      logic [31:0] a_imag;
      sm_type      nr;
      sm_type      ni;
      sm_type      den;
   } mid_type;

   // One result part on its way through the divider: remainder, dividend
   // bits still to be brought down, and the quotient built up in mag.
   typedef struct packed {
      logic              neg;
      logic              big;
      logic [QBITS-1:0]  mag;
      logic [63:0]       rem;
      logic [QBITS-1:0]  bits;
   } lane_type;

   typedef struct packed {
      logic        valid;
      logic        is_div;
      logic        is_divz;
      logic [31:0] a_real;
      logic [31:0] a_imag;
      logic [63:0] den;
   } side_type;

   function automatic sm32_type to_sm(input logic [31:0] v);
      sm32_type r;
      r.neg = v[31];
      r.mag = v[31] ? (~v + 32'd1) : v;
      return r;
   endfunction

   function automatic sm_type ext_sm(input sm32_type x);
      sm_type r;
      r.neg = x.neg;
      r.mag = {32'd0, x.mag};
      return r;
   endfunction

   function automatic sm_type flip_sm(input sm_type x);
      sm_type r;
      r.neg = ~x.neg;
      r.mag = x.mag;
      return r;
   endfunction

   function automatic sm_type sm_add(input sm_type x, input sm_type y);
      sm_type r;
      if (x.neg == y.neg) begin
         r.neg = x.neg;
         r.mag = x.mag + y.mag;
      end else if (x.mag >= y.mag) begin
         r.neg = x.neg;
         r.mag = x.mag - y.mag;
      end else begin
         r.neg = y.neg;
         r.mag = y.mag - x.mag;
      end
      if (r.mag == 64'd0) begin
         r.neg = 1'b0;
      end
      return r;
   endfunction

   // Clamp a sign-magnitude part to 32-bit two's complement; bit 32 is the
   // saturation flag.
   function automatic logic [32:0] sat32(input lane_type x);
      logic [32:0] r;
      if (!x.neg) begin
         if (x.big || x.mag > 33'h0_7FFF_FFFF) begin
            r = {1'b1, 32'h7FFF_FFFF};
         end else begin
            r = {1'b0, x.mag[31:0]};
         end
      end else begin
         if (x.big || x.mag > 33'h0_8000_0000) begin
            r = {1'b1, 32'h8000_0000};
         end else begin
            r = {1'b0, ~x.mag[31:0] + 32'd1};
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/core/cau_mult.sv
// ----------------------------------------------------------------------------
// cau_mult
// Operand decode stage followed by the six partial-product multipliers.
// ----------------------------------------------------------------------------
module cau_mult
   import cau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [1:0]  kind,
   input  logic [31:0] a_real,
   input  logic [31:0] a_imag,
   input  logic [31:0] b_real,
   input  logic [31:0] b_imag,
   input  logic [15:0] tol,
   output prod_type    prod
);

   dec_type  dec_ff, dec_in;
   prod_type prod_ff, prod_in;

   always_comb begin
      dec_in.valid  = accept;
      dec_in.a_real = a_real;
      dec_in.a_imag = a_imag;
      dec_in.ar     = to_sm(a_real);
      dec_in.ai     = to_sm(a_imag);
      dec_in.br     = to_sm(b_real);
      dec_in.bi     = to_sm(b_imag);
      unique case (kind)
         KIND_ADD: dec_in.path = PATH_ADD;
         KIND_SUB: dec_in.path = PATH_SUB;
         KIND_MUL: dec_in.path = PATH_MUL;
         default: begin
            if (dec_in.bi.mag < {16'd0, tol} && dec_in.br.mag != 32'd0) begin
               dec_in.path = PATH_DIVR;
            end else if (dec_in.br.mag == 32'd0 && dec_in.bi.mag == 32'd0) begin
               dec_in.path = PATH_DIVZ;
            end else begin
               dec_in.path = PATH_DIVC;
            end
         end
      endcase
   end

   function automatic sm_type mul_sm(input sm32_type x, input sm32_type y);
      sm_type r;
      r.neg = x.neg ^ y.neg;
      r.mag = {32'd0, x.mag} * {32'd0, y.mag};
      return r;
   endfunction

   always_comb begin
      prod_in.valid  = dec_ff.valid;
      prod_in.path   = dec_ff.path;
      prod_in.a_real = dec_ff.a_real;
      prod_in.a_imag = dec_ff.a_imag;
      prod_in.ar     = dec_ff.ar;
      prod_in.ai     = dec_ff.ai;
      prod_in.br     = dec_ff.br;
      prod_in.bi     = dec_ff.bi;
      prod_in.p_arbr = mul_sm(dec_ff.ar, dec_ff.br);
      prod_in.p_aibi = mul_sm(dec_ff.ai, dec_ff.bi);
      prod_in.p_aibr = mul_sm(dec_ff.ai, dec_ff.br);
      prod_in.p_arbi = mul_sm(dec_ff.ar, dec_ff.bi);
      prod_in.p_brbr = mul_sm(dec_ff.br, dec_ff.br);
      prod_in.p_bibi = mul_sm(dec_ff.bi, dec_ff.bi);
   end

   always_ff @(posedge clock) begin
      dec_ff  <= dec_in;
      prod_ff <= prod_in;
      if (reset) begin
         dec_ff.valid  <= 1'b0;
         prod_ff.valid <= 1'b0;
      end
   end

   assign prod = prod_ff;

endmodule

>>> rtl/core/cau_combine.sv
// ----------------------------------------------------------------------------
// cau_combine
// Sums the partial products per operation and sets up the divider lanes.
// ----------------------------------------------------------------------------
module cau_combine
   import cau_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic     clock,
   input  logic     reset,
   input  prod_type prod,
   output side_type side,
   output lane_type lane_r,
   output lane_type lane_i
);

   localparam int NW = 64 + FRAC_BITS;

   mid_type  mid_ff, mid_in;
   side_type side_ff, side_in;
   lane_type lane_r_ff, lane_r_in, lane_i_ff, lane_i_in;
   sm_type   sum_r, sum_i;

   always_comb begin
      mid_in.valid  = prod.valid;
      mid_in.path   = prod.path;
      mid_in.a_real = prod.a_real;
      mid_in.a_imag = prod.a_imag;
      mid_in.den    = sm_add(prod.p_brbr, prod.p_bibi);
      sum_r         = sm_add(prod.p_arbr, flip_sm(prod.p_aibi));
      sum_i         = sm_add(prod.p_aibr, prod.p_arbi);
      mid_in.nr     = sm_add(prod.p_arbr, prod.p_aibi);
      mid_in.ni     = sm_add(prod.p_aibr, flip_sm(prod.p_arbi));
      case (prod.path)
         PATH_ADD: begin
            mid_in.nr = sm_add(ext_sm(prod.ar), ext_sm(prod.br));
            mid_in.ni = sm_add(ext_sm(prod.ai), ext_sm(prod.bi));
         end
         PATH_SUB: begin
            mid_in.nr = sm_add(ext_sm(prod.ar), flip_sm(ext_sm(prod.br)));
            mid_in.ni = sm_add(ext_sm(prod.ai), flip_sm(ext_sm(prod.bi)));
         end
         default: ;
      endcase
      case (prod.path)
         PATH_MUL: begin
            mid_in.nr.neg = sum_r.neg;
            mid_in.nr.mag = sum_r.mag >> FRAC_BITS;
            mid_in.ni.neg = sum_i.neg;
            mid_in.ni.mag = sum_i.mag >> FRAC_BITS;
         end
         PATH_DIVR: begin
            mid_in.nr  = ext_sm(prod.ar);
            mid_in.ni  = ext_sm(prod.ai);
            mid_in.den = ext_sm(prod.br);
         end
         default: ;
      endcase
   end

   function automatic lane_type init_lane(input mid_type m, input sm_type n);
      lane_type    l;
      logic [NW-1:0] dvd;
      logic [63:0] r0;
      dvd = {n.mag, {FRAC_BITS{1'b0}}};
      r0  = 64'(dvd >> QBITS);
      l.neg = n.neg ^ m.den.neg;
      if (m.path == PATH_DIVR || m.path == PATH_DIVC) begin
         l.big  = (r0 >= m.den.mag);
         l.mag  = '0;
         l.rem  = l.big ? 64'd0 : r0;
         l.bits = l.big ? '0 : dvd[QBITS-1:0];
      end else begin
         l.neg  = n.neg;
         l.big  = |n.mag[63:QBITS];
         l.mag  = n.mag[QBITS-1:0];
         l.rem  = 64'd0;
         l.bits = '0;
      end
      return l;
   endfunction

   always_comb begin
      side_in.valid   = mid_ff.valid;
      side_in.is_div  = (mid_ff.path == PATH_DIVR) || (mid_ff.path == PATH_DIVC);
      side_in.is_divz = (mid_ff.path == PATH_DIVZ);
      side_in.a_real  = mid_ff.a_real;
      side_in.a_imag  = mid_ff.a_imag;
      side_in.den     = mid_ff.den.mag;
      lane_r_in       = init_lane(mid_ff, mid_ff.nr);
      lane_i_in       = init_lane(mid_ff, mid_ff.ni);
   end

   always_ff @(posedge clock) begin
      mid_ff    <= mid_in;
      side_ff   <= side_in;
      lane_r_ff <= lane_r_in;
      lane_i_ff <= lane_i_in;
      if (reset) begin
         mid_ff.valid  <= 1'b0;
         side_ff.valid <= 1'b0;
      end
   end

   assign side   = side_ff;
   assign lane_r = lane_r_ff;
   assign lane_i = lane_i_ff;

endmodule

>>> rtl/core/cau_div_step.sv
// ----------------------------------------------------------------------------
// cau_div_step
// One registered restoring-division step: brings down a dividend bit and
// produces one quotient bit.
// ----------------------------------------------------------------------------
module cau_div_step
   import cau_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] den,
   input  lane_type    lane_i,
   output lane_type    lane_o
);

   lane_type    lane_ff, lane_in;
   logic [64:0] trial;
   logic        ge;

   always_comb begin
      trial   = {lane_i.rem, lane_i.bits[QBITS-1]};
      ge      = (trial >= {1'b0, den});
      lane_in = lane_i;
      if (enable) begin
         lane_in.rem  = ge ? 64'(trial - {1'b0, den}) : trial[63:0];
         lane_in.bits = {lane_i.bits[QBITS-2:0], 1'b0};
         lane_in.mag  = {lane_i.mag[QBITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   assign lane_o = lane_ff;

endmodule

>>> rtl/core/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex add, subtract, multiply and divide on signed fixed point.
// ----------------------------------------------------------------------------
// Usage: a request is taken at each rising edge where start is high and busy
// is low. busy is high only while reset is asserted, so a new request may be
// issued in every cycle. Each request carries the operation kind and the two
// complex operands a and b.
// Every request produces exactly one response, presented on the rsp_ ports
// for a single cycle and marked by rsp_valid; the receiver cannot stall it.
// Throughput is one request per cycle. The pipeline is made of a decode
// stage, a multiplier stage, a summing stage, a divider set-up stage, 33
// registered long-division steps and the output register; every operation
// flows through the whole pipeline.
// The tolerance register is written on the csr_ channel, which is always
// ready; it should only be changed while no request is in flight.
// Reset is synchronous and clears all valid bits and restores the tolerance
// to its reset value; requests in flight are discarded.
// ----------------------------------------------------------------------------
module complex_arith_unit
   import cau_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_a_real,
   input  logic [31:0] req_a_imag,
   input  logic [31:0] req_b_real,
   input  logic [31:0] req_b_imag,
   output logic        rsp_valid,
   output logic [31:0] rsp_res_real,
   output logic [31:0] rsp_res_imag,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int LATENCY = 5 + QBITS;

   logic [15:0] tol_ff;
   prod_type    prod;
   side_type    side_ff [0:QBITS];
   lane_type    lr [0:QBITS];
   lane_type    li [0:QBITS];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] res_real_ff, res_real_in, res_imag_ff, res_imag_in;
   logic [1:0]  status_ff, status_in;
   logic [32:0] sat_r, sat_i;

   // The pipeline never stalls, so requests are refused only during reset.
   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_data;
      end
   end

   cau_mult u_mult (
      .clock  (clock),
      .reset  (reset),
      .accept (start && !busy),
      .kind   (req_kind),
      .a_real (req_a_real),
      .a_imag (req_a_imag),
      .b_real (req_b_real),
      .b_imag (req_b_imag),
      .tol    (tol_ff),
      .prod   (prod)
   );

   cau_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
      .clock  (clock),
      .reset  (reset),
      .prod   (prod),
      .side   (side_ff[0]),
      .lane_r (lr[0]),
      .lane_i (li[0])
   );

   // The division chain: one quotient bit per stage for both result parts.
   // Requests that need no division ride along with their lanes untouched.
   for (genvar k = 0; k < QBITS; k++) begin : g_div
      cau_div_step u_step_r (
         .clock  (clock),
         .enable (side_ff[k].is_div),
         .den    (side_ff[k].den),
         .lane_i (lr[k]),
         .lane_o (lr[k+1])
      );
      cau_div_step u_step_i (
         .clock  (clock),
         .enable (side_ff[k].is_div),
         .den    (side_ff[k].den),
         .lane_i (li[k]),
         .lane_o (li[k+1])
      );
      always_ff @(posedge clock) begin
         side_ff[k+1] <= side_ff[k];
         if (reset) begin
            side_ff[k+1].valid <= 1'b0;
         end
      end
   end

   // Output stage: a divide by zero hands back operand a, anything else is
   // clamped to 32 bits with the saturation status raised if either part
   // had to be clamped.
   always_comb begin
      sat_r        = sat32(lr[QBITS]);
      sat_i        = sat32(li[QBITS]);
      rsp_valid_in = side_ff[QBITS].valid;
      if (side_ff[QBITS].is_divz) begin
         res_real_in = side_ff[QBITS].a_real;
         res_imag_in = side_ff[QBITS].a_imag;
         status_in   = STATUS_DIVZ;
      end else begin
         res_real_in = sat_r[31:0];
         res_imag_in = sat_i[31:0];
         status_in   = (sat_r[32] || sat_i[32]) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      res_real_ff <= res_real_in;
      res_imag_ff <= res_imag_in;
      status_ff   <= status_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_real = res_real_ff;
   assign rsp_res_imag = res_imag_ff;
   assign rsp_status   = status_ff;

`ifndef ASSERT_OFF
   // Every response traces back to a request accepted a fixed time earlier.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without a matching request");

   // The status code never takes the unused value.
   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_DIVZ ||
                     rsp_status == STATUS_SAT))
      else $error("undefined status code");

   // A saturated response has at least one part pinned at a bound.
   a_sat_bound : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_SAT) |->
         (rsp_res_real == 32'h7FFF_FFFF || rsp_res_real == 32'h8000_0000 ||
          rsp_res_imag == 32'h7FFF_FFFF || rsp_res_imag == 32'h8000_0000))
      else $error("saturation status without a clamped part");
`endif

endmodule

>>> tb/sv/tb_complex_arith_unit.sv
// ----------------------------------------------------------------------------
// tb_complex_arith_unit
// Self-checking testbench for the complex arithmetic unit. Requests are sent
// through the start/busy handshake with random gaps. Each accepted request is
// predicted in place, and every response strobe is checked against the
// oldest prediction. The tolerance register is changed only while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module tb_complex_arith_unit
   import cau_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC   = 16;
   localparam int LATENCY = 38;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1600;

   // Sign-magnitude value that is wide enough for every exact product and sum.
   typedef struct {
      bit        neg;
      bit [63:0] mag;
   } sgnmag_type;

   typedef struct {
      bit [31:0] res_real;
      bit [31:0] res_imag;
      bit [1:0]  status;
   } cplx_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = KIND_ADD;
   logic [31:0] req_a_real = '0;
   logic [31:0] req_a_imag = '0;
   logic [31:0] req_b_real = '0;
   logic [31:0] req_b_imag = '0;
   logic        rsp_valid;
   logic [31:0] rsp_res_real;
   logic [31:0] rsp_res_imag;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   cplx_result_type pending_results[$];
   bit [15:0]    tolerance = TOL_RESET;
   int           mismatches = 0;
   int           cycle_count = 0;
   int           idle_pct = 33;

   complex_arith_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_a_real   (req_a_real),
      .req_a_imag   (req_a_imag),
      .req_b_real   (req_b_real),
      .req_b_imag   (req_b_imag),
      .rsp_valid    (rsp_valid),
      .rsp_res_real (rsp_res_real),
      .rsp_res_imag (rsp_res_imag),
      .rsp_status   (rsp_status),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // A runaway run is stopped here; a hang in either handshake ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Predictor. Every part is computed exactly in sign-magnitude, truncated
   // toward zero, and clamped to 32 bits at the end.
   // ------------------------------------------------------------------------
   function automatic sgnmag_type sm_of(bit [31:0] v);
      sgnmag_type r;
      r.neg = v[31];
      r.mag = v[31] ? 64'h1_0000_0000 - {32'd0, v} : {32'd0, v};
      return r;
   endfunction

   function automatic sgnmag_type sm_negate(sgnmag_type x);
      if (x.mag != 0) x.neg = !x.neg;
      return x;
   endfunction

   function automatic sgnmag_type sm_times(sgnmag_type x, sgnmag_type y);
      sgnmag_type r;
      r.mag = x.mag * y.mag;
      r.neg = (r.mag != 0) && (x.neg != y.neg);
      return r;
   endfunction

   function automatic sgnmag_type sm_plus(sgnmag_type x, sgnmag_type y);
      sgnmag_type r;
      if (x.neg == y.neg) begin
         r.neg = x.neg;
         r.mag = x.mag + y.mag;
      end else if (x.mag >= y.mag) begin
         r.neg = x.neg;
         r.mag = x.mag - y.mag;
      end else begin
         r.neg = y.neg;
         r.mag = y.mag - x.mag;
      end
      if (r.mag == 0) r.neg = 1'b0;
      return r;
   endfunction

   function automatic sgnmag_type sm_drop_frac(sgnmag_type x);
      x.mag = x.mag >> FRAC;
      if (x.mag == 0) x.neg = 1'b0;
      return x;
   endfunction

   // The quotient is capped at 2^33, which is far enough past the
   // 32-bit range that saturation comes out the same.
   function automatic sgnmag_type sm_over(sgnmag_type n, sgnmag_type d);
      sgnmag_type  r;
      bit [95:0] quo;
      quo = ({32'd0, n.mag} << FRAC) / {32'd0, d.mag};
      if (quo > (96'd1 << 33)) quo = 96'd1 << 33;
      r.mag = quo[63:0];
      r.neg = (r.mag != 0) && (n.neg != d.neg);
      return r;
   endfunction

   function automatic bit [31:0] clamp32(sgnmag_type x, ref bit clipped);
      if (!x.neg) begin
         if (x.mag > 64'h7FFF_FFFF) begin
            clipped = 1'b1;
            return 32'h7FFF_FFFF;
         end
         return x.mag[31:0];
      end
      if (x.mag > 64'h8000_0000) begin
         clipped = 1'b1;
         return 32'h8000_0000;
      end
      return 32'd0 - x.mag[31:0];
   endfunction

   function automatic cplx_result_type predict_result(bit [1:0] kind, bit [31:0] a_re,
                                                       bit [31:0] a_im, bit [31:0] b_re,
                                                       bit [31:0] b_im);
      cplx_result_type res;
      sgnmag_type ar, ai, br, bi, rr, ri, den, nr, ni;
      bit clipped;
      ar = sm_of(a_re);
      ai = sm_of(a_im);
      br = sm_of(b_re);
      bi = sm_of(b_im);
      clipped = 1'b0;
      if (kind == KIND_ADD) begin
         rr = sm_plus(ar, br);
         ri = sm_plus(ai, bi);
      end else if (kind == KIND_SUB) begin
         rr = sm_plus(ar, sm_negate(br));
         ri = sm_plus(ai, sm_negate(bi));
      end else if (kind == KIND_MUL) begin
         rr = sm_drop_frac(sm_plus(sm_times(ar, br), sm_negate(sm_times(ai, bi))));
         ri = sm_drop_frac(sm_plus(sm_times(ai, br), sm_times(ar, bi)));
      end else if (bi.mag < {48'd0, tolerance} && br.mag != 0) begin
         // Divisor counts as real: both parts of a are divided by b_real.
         rr = sm_over(ar, br);
         ri = sm_over(ai, br);
      end else if (br.mag == 0 && bi.mag == 0) begin
         res.res_real = a_re;
         res.res_imag = a_im;
         res.status   = STATUS_DIVZ;
         return res;
      end else begin
         den = sm_plus(sm_times(br, br), sm_times(bi, bi));
         nr  = sm_plus(sm_times(ar, br), sm_times(ai, bi));
         ni  = sm_plus(sm_times(ai, br), sm_negate(sm_times(ar, bi)));
         rr  = sm_over(nr, den);
         ri  = sm_over(ni, den);
      end
      res.res_real = clamp32(rr, clipped);
      res.res_imag = clamp32(ri, clipped);
      res.status   = clipped ? STATUS_SAT : STATUS_OK;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Response checker: the unit cannot be stalled, so every strobe is taken.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cplx_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: real %h imag %h status %0d",
                        rsp_res_real, rsp_res_imag, rsp_status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_res_real !== want.res_real || rsp_res_imag !== want.res_imag ||
                rsp_status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h %h %0d, got %h %h %0d",
                           want.res_real, want.res_imag, want.status,
                           rsp_res_real, rsp_res_imag, rsp_status);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request driver. Gaps are inserted at random unless idle_pct is zero; the
   // prediction is queued once the request has been taken.
   // ------------------------------------------------------------------------
   task automatic send_request(bit [1:0] kind, bit [31:0] a_re, bit [31:0] a_im,
                               bit [31:0] b_re, bit [31:0] b_im);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_kind   <= kind;
      req_a_real <= a_re;
      req_a_imag <= a_im;
      req_b_real <= b_re;
      req_b_imag <= b_im;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_result(kind, a_re, a_im, b_re, b_im));
   endtask

   // Stop sending and wait until every response is back, plus a margin.
   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tolerance(bit [15:0] value);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tolerance = value;
   endtask

   // Operand values weighted towards the interesting corners.
   function automatic bit [31:0] pick_operand();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'd0;
         3:       return $urandom_range(15) - 8;
         4:       return $urandom_range(131071) - 65536;
         5:       return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // Divisor imaginary parts clustered around the current tolerance bound.
   function automatic bit [31:0] pick_divisor_imag();
      bit [31:0] m;
      case ($urandom_range(4))
         0: return 32'd0;
         1: begin
            m = {16'd0, tolerance} + $urandom_range(2) - 1;
            return $urandom_range(1) ? m : 32'd0 - m;
         end
         2: return $urandom_range(1) ? {16'd0, tolerance} : 32'd0 - {16'd0, tolerance};
         default: return pick_operand();
      endcase
   endfunction

   task automatic send_random(int count);
      bit [1:0]  kind;
      bit [31:0] b_re, b_im;
      repeat (count) begin
         kind = 2'($urandom_range(3));
         b_re = pick_operand();
         b_im = (kind == KIND_DIV) ? pick_divisor_imag() : pick_operand();
         if (kind == KIND_DIV && $urandom_range(15) == 0) begin
            b_re = 32'd0;
            b_im = 32'd0;
         end
         send_request(kind, pick_operand(), pick_operand(), b_re, b_im);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      send_request(KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
      send_request(KIND_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(KIND_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_4000);
      send_request(KIND_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      send_request(KIND_SUB, 32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_request(KIND_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(KIND_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000);
      send_request(KIND_MUL, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
      // Divide by zero hands back a unchanged.
      send_request(KIND_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
      send_request(KIND_DIV, 32'h1234_5678, 32'hFEDC_BA98, 32'd0, 32'd0);
      // Tiny imaginary divisor part is ignored, including when nonzero.
      send_request(KIND_DIV, 32'h0006_0000, 32'hFFFD_0000, 32'h0002_0000, 32'h0000_0006);
      send_request(KIND_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFA);
      send_request(KIND_DIV, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'd0);
      // Imaginary part exactly at the tolerance takes the general path.
      send_request(KIND_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0007);
      send_request(KIND_DIV, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'h0001_0000);
      send_request(KIND_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0100);
      send_request(KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_request(KIND_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFF_0000);
   endtask

   task automatic test_tolerance_sweep();
      bit [15:0] settings[4];
      settings = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom)};
      foreach (settings[i]) begin
         write_tolerance(settings[i]);
         send_request(KIND_DIV, 32'h0005_0000, 32'hFFFB_0000, 32'h0001_0000, 32'd0);
         send_request(KIND_DIV, 32'h0005_0000, 32'hFFFB_0000, 32'h0001_0000,
                      {16'd0, settings[i]});
         send_request(KIND_DIV, 32'h0005_0000, 32'hFFFB_0000, 32'hFFFF_0000,
                      32'd0 - {16'd0, settings[i]} + 32'd1);
         send_random(12);
      end
      write_tolerance(TOL_RESET);
   endtask

   task automatic test_random_traffic();
      // A stretch with no gaps at all keeps the pipeline completely full.
      idle_pct = 0;
      send_random(300);
      idle_pct = 33;
      send_random(RANDOM_ITEMS / 2 - 300);
      // Sender holds off until the pipeline has emptied out.
      drain_pipeline();
      write_tolerance(16'($urandom_range(1, 200)));
      send_random(RANDOM_ITEMS / 2);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_tolerance_sweep();
      test_random_traffic();
      drain_pipeline();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/cau_pkg.sv
rtl/core/cau_mult.sv
rtl/core/cau_combine.sv
rtl/core/cau_div_step.sv
rtl/core/complex_arith_unit.sv
tb/sv/tb_complex_arith_unit.sv
